// ===== src/hdf_pkg.sv =====
`timescale 1ns / 1ps

package hdf_pkg;

   localparam int unsigned QUEUE_DEPTH = 2;
   localparam int unsigned QUEUE_PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int unsigned QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   localparam logic [1:0] LEN_LAST_BYTE = 2'd3;

   typedef enum logic [1:0] {
      FUNC_START  = 2'd0,
      FUNC_BYTE   = 2'd1,
      FUNC_FINISH = 2'd2,
      FUNC_NONE   = 2'd3
   } func_type;

   typedef enum logic [1:0] {
      KIND_BEGIN = 2'd0,
      KIND_DATA  = 2'd1,
      KIND_OK    = 2'd2,
      KIND_ERR   = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      ERR_EMPTY   = 2'd0,
      ERR_ORDER   = 2'd1,
      ERR_CUT     = 2'd2,
      ERR_MISSING = 2'd3
   } err_type;

   typedef enum logic [1:0] {
      OP_START  = 2'd0,
      OP_BYTE   = 2'd1,
      OP_FINISH = 2'd2
   } op_type;

   typedef struct packed {
      op_type     op;
      logic [7:0] segment_index;
      logic [7:0] body_byte;
      logic       segment_last;
   } item_type;

   typedef struct packed {
      kind_type    kind;
      logic [31:0] header_number;
      logic [31:0] header_length;
      logic [31:0] merged_offset;
      logic [7:0]  data_byte;
      logic        header_done;
      err_type     error_code;
   } result_type;

endpackage

// ===== src/hdf_req_if.sv =====
`timescale 1ns / 1ps

interface hdf_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] func;
   logic [7:0] segment_index;
   logic [7:0] body_byte;
   logic       segment_last;

   modport source (output valid, func, segment_index, body_byte, segment_last,
                   input ready);
   modport sink (input valid, func, segment_index, body_byte, segment_last,
                 output ready);
endinterface

// ===== src/hdf_rsp_if.sv =====
`timescale 1ns / 1ps

interface hdf_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  kind;
   logic [31:0] header_number;
   logic [31:0] header_length;
   logic [31:0] merged_offset;
   logic [7:0]  data_byte;
   logic        header_done;
   logic [1:0]  error_code;

   modport source (output valid, kind, header_number, header_length, merged_offset,
                   data_byte, header_done, error_code, input ready);
   modport sink (input valid, kind, header_number, header_length, merged_offset,
                 data_byte, header_done, error_code, output ready);
endinterface

// ===== src/hdf_front.sv =====
`timescale 1ns / 1ps

module hdf_front (
   input  logic              clock,
   input  logic              reset,
   hdf_req_if.sink           req_bus,
   output logic              q_valid,
   output hdf_pkg::item_type q_item,
   input  logic              q_pop
);

   hdf_pkg::item_type                        queue_ff [hdf_pkg::QUEUE_DEPTH];
   logic [hdf_pkg::QUEUE_PTR_W-1:0]          wr_ptr_ff, wr_ptr_in;
   logic [hdf_pkg::QUEUE_PTR_W-1:0]          rd_ptr_ff, rd_ptr_in;
   logic [hdf_pkg::QUEUE_CNT_W-1:0]          count_ff, count_in;
   hdf_pkg::item_type                        item;
   logic                                     keep;
   logic                                     push;

   // classify the beat; unknown func codes are taken and dropped
   always_comb begin
      keep               = 1'b1;
      item.op            = hdf_pkg::OP_START;
      item.segment_index = req_bus.segment_index;
      item.body_byte     = req_bus.body_byte;
      item.segment_last  = req_bus.segment_last;
      unique case (hdf_pkg::func_type'(req_bus.func))
         hdf_pkg::FUNC_START:  item.op = hdf_pkg::OP_START;
         hdf_pkg::FUNC_BYTE:   item.op = hdf_pkg::OP_BYTE;
         hdf_pkg::FUNC_FINISH: item.op = hdf_pkg::OP_FINISH;
         default:              keep = 1'b0;
      endcase
   end

   assign req_bus.ready = (count_ff != hdf_pkg::QUEUE_CNT_W'(hdf_pkg::QUEUE_DEPTH));
   assign push          = req_bus.valid && req_bus.ready && keep;
   assign q_valid       = (count_ff != '0);
   assign q_item        = queue_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         if (wr_ptr_ff == hdf_pkg::QUEUE_PTR_W'(hdf_pkg::QUEUE_DEPTH - 1)) begin
            wr_ptr_in = '0;
         end else begin
            wr_ptr_in = wr_ptr_ff + 1'b1;
         end
      end
      if (q_pop) begin
         if (rd_ptr_ff == hdf_pkg::QUEUE_PTR_W'(hdf_pkg::QUEUE_DEPTH - 1)) begin
            rd_ptr_in = '0;
         end else begin
            rd_ptr_in = rd_ptr_ff + 1'b1;
         end
      end
      if (push && !q_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!push && q_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= item;
      end
   end

endmodule

// ===== src/hdf_back.sv =====
`timescale 1ns / 1ps

module hdf_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              q_valid,
   input  hdf_pkg::item_type q_item,
   output logic              q_pop,
   hdf_rsp_if.source         rsp_bus
);

   logic                 reading_length_ff, reading_length_in;
   logic [1:0]           len_seen_ff, len_seen_in;
   logic [31:0]          len_acc_ff, len_acc_in;
   logic [31:0]          data_left_ff, data_left_in;
   logic [31:0]          header_count_ff, header_count_in;
   logic [31:0]          total_offset_ff, total_offset_in;
   logic [7:0]           prev_index_ff, prev_index_in;
   logic                 any_seen_ff, any_seen_in;
   logic                 has_body_ff, has_body_in;
   logic                 failed_ff, failed_in;
   logic                 seg_open_ff, seg_open_in;
   hdf_pkg::err_type     err_latched_ff, err_latched_in;
   logic                 out_valid_ff, out_valid_in;
   hdf_pkg::result_type  out_ff;
   hdf_pkg::result_type  res;
   logic                 emit;
   logic                 empty_err;
   logic                 cut_err;
   logic [31:0]          acc_next;
   logic [31:0]          left_next;

   assign q_pop     = q_valid && (!out_valid_ff || rsp_bus.ready);
   assign empty_err = seg_open_ff && !has_body_ff;
   assign cut_err   = seg_open_ff && reading_length_ff && (len_seen_ff != 2'd0);
   assign acc_next  = {len_acc_ff[23:0], q_item.body_byte};
   assign left_next = data_left_ff - 32'd1;

   always_comb begin
      reading_length_in = reading_length_ff;
      len_seen_in       = len_seen_ff;
      len_acc_in        = len_acc_ff;
      data_left_in      = data_left_ff;
      header_count_in   = header_count_ff;
      total_offset_in   = total_offset_ff;
      prev_index_in     = prev_index_ff;
      any_seen_in       = any_seen_ff;
      has_body_in       = has_body_ff;
      failed_in         = failed_ff;
      seg_open_in       = seg_open_ff;
      err_latched_in    = err_latched_ff;
      emit              = 1'b0;
      res               = '0;
      if (q_pop) begin
         unique case (q_item.op)
            hdf_pkg::OP_FINISH: begin
               emit     = 1'b1;
               res.kind = hdf_pkg::KIND_ERR;
               if (failed_ff) begin
                  res.error_code = err_latched_ff;
               end else if (empty_err) begin
                  res.error_code = hdf_pkg::ERR_EMPTY;
               end else if (cut_err) begin
                  res.error_code = hdf_pkg::ERR_CUT;
               end else if (data_left_ff != 32'd0) begin
                  res.error_code = hdf_pkg::ERR_MISSING;
               end else begin
                  res.kind          = hdf_pkg::KIND_OK;
                  res.header_number = header_count_ff;
                  res.merged_offset = total_offset_ff;
               end
               // a finish ends the run and puts everything back to reset values
               reading_length_in = 1'b1;
               len_seen_in       = 2'd0;
               len_acc_in        = '0;
               data_left_in      = '0;
               header_count_in   = '0;
               total_offset_in   = '0;
               prev_index_in     = '0;
               any_seen_in       = 1'b0;
               has_body_in       = 1'b0;
               failed_in         = 1'b0;
               seg_open_in       = 1'b0;
               err_latched_in    = hdf_pkg::ERR_EMPTY;
            end
            hdf_pkg::OP_START: begin
               if (!failed_ff) begin
                  res.kind = hdf_pkg::KIND_ERR;
                  if (empty_err || cut_err ||
                      (any_seen_ff && (q_item.segment_index <= prev_index_ff))) begin
                     emit        = 1'b1;
                     failed_in   = 1'b1;
                     seg_open_in = 1'b0;
                     if (empty_err) begin
                        res.error_code = hdf_pkg::ERR_EMPTY;
                     end else if (cut_err) begin
                        res.error_code = hdf_pkg::ERR_CUT;
                     end else begin
                        res.error_code = hdf_pkg::ERR_ORDER;
                     end
                     err_latched_in = res.error_code;
                  end else begin
                     prev_index_in = q_item.segment_index;
                     any_seen_in   = 1'b1;
                     seg_open_in   = 1'b1;
                     has_body_in   = 1'b0;
                  end
               end
            end
            hdf_pkg::OP_BYTE: begin
               // stray bytes outside a segment are dropped
               if (!failed_ff && seg_open_ff) begin
                  has_body_in = 1'b1;
                  if (q_item.segment_last) begin
                     seg_open_in = 1'b0;
                  end
                  if (reading_length_ff) begin
                     if (len_seen_ff != hdf_pkg::LEN_LAST_BYTE) begin
                        len_acc_in  = acc_next;
                        len_seen_in = len_seen_ff + 2'd1;
                        if (q_item.segment_last) begin
                           // length field may not span segments
                           emit           = 1'b1;
                           failed_in      = 1'b1;
                           res.kind       = hdf_pkg::KIND_ERR;
                           res.error_code = hdf_pkg::ERR_CUT;
                           err_latched_in = hdf_pkg::ERR_CUT;
                        end
                     end else begin
                        emit              = 1'b1;
                        res.kind          = hdf_pkg::KIND_BEGIN;
                        res.header_number = header_count_ff;
                        res.header_length = acc_next;
                        res.merged_offset = total_offset_ff;
                        res.header_done   = (acc_next == 32'd0);
                        len_seen_in       = 2'd0;
                        len_acc_in        = '0;
                        if (acc_next == 32'd0) begin
                           header_count_in = header_count_ff + 32'd1;
                        end else begin
                           data_left_in      = acc_next;
                           reading_length_in = 1'b0;
                        end
                     end
                  end else begin
                     emit              = 1'b1;
                     res.kind          = hdf_pkg::KIND_DATA;
                     res.header_number = header_count_ff;
                     res.merged_offset = total_offset_ff;
                     res.data_byte     = q_item.body_byte;
                     res.header_done   = (left_next == 32'd0);
                     data_left_in      = left_next;
                     total_offset_in   = total_offset_ff + 32'd1;
                     if (left_next == 32'd0) begin
                        header_count_in   = header_count_ff + 32'd1;
                        reading_length_in = 1'b1;
                     end
                  end
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      if (q_pop && emit) begin
         out_valid_in = 1'b1;
      end else if (rsp_bus.ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         reading_length_ff <= 1'b1;
         len_seen_ff       <= 2'd0;
         len_acc_ff        <= '0;
         data_left_ff      <= '0;
         header_count_ff   <= '0;
         total_offset_ff   <= '0;
         prev_index_ff     <= '0;
         any_seen_ff       <= 1'b0;
         has_body_ff       <= 1'b0;
         failed_ff         <= 1'b0;
         seg_open_ff       <= 1'b0;
         err_latched_ff    <= hdf_pkg::ERR_EMPTY;
         out_valid_ff      <= 1'b0;
      end else begin
         reading_length_ff <= reading_length_in;
         len_seen_ff       <= len_seen_in;
         len_acc_ff        <= len_acc_in;
         data_left_ff      <= data_left_in;
         header_count_ff   <= header_count_in;
         total_offset_ff   <= total_offset_in;
         prev_index_ff     <= prev_index_in;
         any_seen_ff       <= any_seen_in;
         has_body_ff       <= has_body_in;
         failed_ff         <= failed_in;
         seg_open_ff       <= seg_open_in;
         err_latched_ff    <= err_latched_in;
         out_valid_ff      <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop && emit) begin
         out_ff <= res;
      end
   end

   assign rsp_bus.valid         = out_valid_ff;
   assign rsp_bus.kind          = out_ff.kind;
   assign rsp_bus.header_number = out_ff.header_number;
   assign rsp_bus.header_length = out_ff.header_length;
   assign rsp_bus.merged_offset = out_ff.merged_offset;
   assign rsp_bus.data_byte     = out_ff.data_byte;
   assign rsp_bus.header_done   = out_ff.header_done;
   assign rsp_bus.error_code    = out_ff.error_code;

endmodule

// ===== src/packed_header_deframer.sv =====
`timescale 1ns / 1ps

// channel   dir  handshake      payload
// req_bus   in   valid / ready  func, segment_index, body_byte, segment_last
// rsp_bus   out  valid / ready  kind, header_number, header_length, merged_offset,
//                               data_byte, header_done, error_code
//
// one beat per cycle sustained while results are taken; an accepted beat waits in the
// classify queue, then the state update loads its result into the output register.
// the back end retires one queued beat per cycle whenever the output register is
// empty or being taken; a 2-entry queue lets the input side run on during a stall.
// synchronous reset clears the queue, the output register and all header state.

module packed_header_deframer (
   input  logic      clock,
   input  logic      reset,
   hdf_req_if.sink   req_bus,
   hdf_rsp_if.source rsp_bus
);

   logic              q_valid;
   logic              q_pop;
   hdf_pkg::item_type q_item;

   hdf_front u_front (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .q_valid (q_valid),
      .q_item  (q_item),
      .q_pop   (q_pop)
   );

   hdf_back u_back (
      .clock   (clock),
      .reset   (reset),
      .q_valid (q_valid),
      .q_item  (q_item),
      .q_pop   (q_pop),
      .rsp_bus (rsp_bus)
   );

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
   import hdf_pkg::*;

   localparam int CYCLE_LIMIT = 500000;
   localparam int RANDOM_BEATS = 1800;
   localparam int CALM_TAIL = 200;

   typedef struct packed {
      func_type   func;
      logic [7:0] segment_index;
      logic [7:0] body_byte;
      logic       segment_last;
   } deframer_beat_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   hdf_req_if req_bus ();
   hdf_rsp_if rsp_bus ();

   packed_header_deframer dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   logic       drv_valid = 1'b0;
   logic [1:0] drv_func = 2'd0;
   logic [7:0] drv_index = 8'd0;
   logic [7:0] drv_byte = 8'd0;
   logic       drv_last = 1'b0;
   logic       take_rsp = 1'b0;

   assign req_bus.valid = drv_valid;
   assign req_bus.func = drv_func;
   assign req_bus.segment_index = drv_index;
   assign req_bus.body_byte = drv_byte;
   assign req_bus.segment_last = drv_last;
   assign rsp_bus.ready = take_rsp;

   initial begin
      forever #2 clock = ~clock;
   end

   deframer_beat_type pending_beats [$];
   result_type        expected_reports [$];

   // header merge state as the block should hold it
   logic        want_length = 1'b1;
   logic [1:0]  len_count = 2'd0;
   logic [31:0] len_acc = 32'd0;
   logic [31:0] bytes_left = 32'd0;
   logic [31:0] hdr_count = 32'd0;
   logic [31:0] offset_total = 32'd0;
   logic [7:0]  last_index = 8'd0;
   logic        seen_segment = 1'b0;
   logic        seg_has_body = 1'b0;
   logic        seg_open = 1'b0;
   logic        is_failed = 1'b0;
   err_type     fail_code = ERR_EMPTY;

   int fail_count = 0;
   int checked_count = 0;
   int ok_count = 0;
   int err_count = 0;
   int begin_count = 0;
   int frame_count = 0;
   int counted_beats = 0;
   int beats_total = 0;
   int n_accepted = 0;
   int cycle_count = 0;
   bit noise_on = 1'b0;

   function automatic bit burst_now(input int mode);
      if (pending_beats.size() < CALM_TAIL) return 1'b0;
      case (mode)
         1: return $urandom_range(0, 15) == 0;
         2: return $urandom_range(0, 3) == 0;
         default: return 1'b0;
      endcase
   endfunction

   // checks done whenever the open segment gets closed
   task automatic closing_fault(output bit fault, output err_type code);
      fault = 1'b0;
      code = ERR_EMPTY;
      if (seg_open && !seg_has_body) begin
         fault = 1'b1;
         code = ERR_EMPTY;
      end else if (seg_open && want_length && len_count != 2'd0) begin
         fault = 1'b1;
         code = ERR_CUT;
      end
   endtask

   task automatic latch_fault(input err_type code);
      result_type r;
      r = '0;
      r.kind = KIND_ERR;
      r.error_code = code;
      is_failed = 1'b1;
      fail_code = code;
      seg_open = 1'b0;
      expected_reports.insert(expected_reports.size(), r);
   endtask

   task automatic deframe_beat(input deframer_beat_type it);
      result_type r;
      bit fault;
      err_type code;
      r = '0;
      case (it.func)
         FUNC_FINISH: begin
            if (is_failed) begin
               r.kind = KIND_ERR;
               r.error_code = fail_code;
            end else begin
               closing_fault(fault, code);
               if (!fault && bytes_left != 32'd0) begin
                  fault = 1'b1;
                  code = ERR_MISSING;
               end
               if (fault) begin
                  r.kind = KIND_ERR;
                  r.error_code = code;
               end else begin
                  r.kind = KIND_OK;
                  r.header_number = hdr_count;
                  r.merged_offset = offset_total;
               end
            end
            expected_reports.insert(expected_reports.size(), r);
            // finish returns everything to the reset state
            want_length = 1'b1;
            len_count = 2'd0;
            len_acc = 32'd0;
            bytes_left = 32'd0;
            hdr_count = 32'd0;
            offset_total = 32'd0;
            last_index = 8'd0;
            seen_segment = 1'b0;
            seg_has_body = 1'b0;
            seg_open = 1'b0;
            is_failed = 1'b0;
            fail_code = ERR_EMPTY;
         end
         FUNC_START: begin
            if (!is_failed) begin
               closing_fault(fault, code);
               if (!fault && seen_segment && it.segment_index <= last_index) begin
                  fault = 1'b1;
                  code = ERR_ORDER;
               end
               if (fault) begin
                  latch_fault(code);
               end else begin
                  last_index = it.segment_index;
                  seen_segment = 1'b1;
                  seg_open = 1'b1;
                  seg_has_body = 1'b0;
               end
            end
         end
         FUNC_BYTE: begin
            if (!is_failed && seg_open) begin
               seg_has_body = 1'b1;
               if (want_length) begin
                  len_acc = {len_acc[23:0], it.body_byte};
                  if (len_count != LEN_LAST_BYTE) begin
                     len_count = len_count + 2'd1;
                     // a length field may not run past the segment end
                     if (it.segment_last) latch_fault(ERR_CUT);
                  end else begin
                     r.kind = KIND_BEGIN;
                     r.header_number = hdr_count;
                     r.header_length = len_acc;
                     r.merged_offset = offset_total;
                     r.header_done = (len_acc == 32'd0);
                     expected_reports.insert(expected_reports.size(), r);
                     len_count = 2'd0;
                     len_acc = 32'd0;
                     if (r.header_done) begin
                        hdr_count = hdr_count + 32'd1;
                     end else begin
                        bytes_left = r.header_length;
                        want_length = 1'b0;
                     end
                     if (it.segment_last) seg_open = 1'b0;
                  end
               end else begin
                  bytes_left = bytes_left - 32'd1;
                  r.kind = KIND_DATA;
                  r.header_number = hdr_count;
                  r.merged_offset = offset_total;
                  r.data_byte = it.body_byte;
                  r.header_done = (bytes_left == 32'd0);
                  expected_reports.insert(expected_reports.size(), r);
                  offset_total = offset_total + 32'd1;
                  if (r.header_done) begin
                     hdr_count = hdr_count + 32'd1;
                     want_length = 1'b1;
                  end
                  if (it.segment_last) seg_open = 1'b0;
               end
            end
         end
         default: ;
      endcase
   endtask

   task automatic add_beat(input func_type f, input logic [7:0] idx, input logic [7:0] b,
                           input logic last);
      deframer_beat_type beat;
      if (noise_on && $urandom_range(0, 39) == 0) begin
         beat.func = FUNC_NONE;
         beat.segment_index = 8'($urandom);
         beat.body_byte = 8'($urandom);
         beat.segment_last = 1'($urandom);
         pending_beats.insert(pending_beats.size(), beat);
      end
      beat.func = f;
      beat.segment_index = idx;
      beat.body_byte = b;
      beat.segment_last = last;
      pending_beats.insert(pending_beats.size(), beat);
      if (f != FUNC_NONE) counted_beats++;
   endtask

   task automatic put_len(input logic [31:0] len, input logic last);
      for (int k = 3; k >= 0; k--) begin
         add_beat(FUNC_BYTE, 8'd0, len[8*k +: 8], last && k == 0);
      end
   endtask

   // one run of segments closed by a finish; flawed runs carry one kind of defect
   task automatic queue_frame(input bit flawed);
      byte unsigned stream [$];
      bit splittable [$];
      logic [31:0] hdr_len;
      int n_hdr, fault, fault_seg, seg_no, pos, stop, idx, prev_idx, drop;
      bit mark;
      deframer_beat_type stray;
      n_hdr = $urandom_range(1, 6);
      for (int h = 0; h < n_hdr; h++) begin
         hdr_len = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 40) : $urandom_range(0, 6);
         for (int k = 3; k >= 0; k--) begin
            stream.insert(stream.size(), hdr_len[8*k +: 8]);
            splittable.insert(splittable.size(), k == 3);
         end
         for (int i = 0; i < int'(hdr_len); i++) begin
            stream.insert(stream.size(), 8'($urandom));
            splittable.insert(splittable.size(), 1'b1);
         end
      end
      fault = flawed ? $urandom_range(1, 5) : 0;
      fault_seg = $urandom_range(0, 3);
      if (fault == 4) begin
         // chop the tail: ends inside a length field or short of header data
         drop = $urandom_range(1, 5);
         if (drop > stream.size() - 1) drop = stream.size() - 1;
         repeat (drop) begin
            void'(stream.pop_back());
            void'(splittable.pop_back());
         end
      end else if (fault == 5) begin
         // huge length with no data behind it
         hdr_len = $urandom;
         for (int k = 3; k >= 0; k--) begin
            stream.insert(stream.size(), hdr_len[8*k +: 8]);
            splittable.insert(splittable.size(), k == 3);
         end
      end
      idx = ($urandom_range(0, 4) == 0) ? $urandom_range(150, 230) : $urandom_range(0, 60);
      prev_idx = idx;
      pos = 0;
      seg_no = 0;
      while (pos < stream.size()) begin
         if (fault == 1 && seg_no == fault_seg) begin
            add_beat(FUNC_START, 8'(idx), 8'($urandom), 1'($urandom));
            idx = idx + 1;
         end
         if (fault == 2 && seg_no == fault_seg && seg_no > 0) begin
            idx = prev_idx - $urandom_range(0, (prev_idx < 3) ? prev_idx : 3);
         end
         add_beat(FUNC_START, 8'(idx), 8'($urandom), 1'($urandom));
         stop = pos + $urandom_range(1, 12);
         if (idx >= 240 || stop > stream.size()) stop = stream.size();
         if (!(fault == 3 && seg_no == fault_seg)) begin
            while (stop < stream.size() && !splittable[stop]) stop++;
         end
         mark = $urandom_range(0, 4) != 0;
         for (int i = pos; i < stop; i++) begin
            add_beat(FUNC_BYTE, 8'($urandom), stream[i], mark && i == stop - 1);
         end
         pos = stop;
         if (mark && $urandom_range(0, 7) == 0) begin
            // byte between segments, nothing open to take it
            stray.func = FUNC_BYTE;
            stray.segment_index = 8'($urandom);
            stray.body_byte = 8'($urandom);
            stray.segment_last = 1'($urandom);
            pending_beats.insert(pending_beats.size(), stray);
         end
         prev_idx = idx;
         idx = idx + $urandom_range(1, 4);
         seg_no++;
      end
      add_beat(FUNC_FINISH, 8'($urandom), 8'($urandom), 1'($urandom));
      frame_count++;
   endtask

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
         fail_count++;
      end
   endtask

   task automatic check_report();
      result_type want;
      if (expected_reports.size() == 0) begin
         $display("%0t: unexpected result, kind %0d", $time, rsp_bus.kind);
         fail_count++;
      end else begin
         want = expected_reports.pop_front();
         check_field("kind", 32'(want.kind), 32'(rsp_bus.kind));
         check_field("header_number", want.header_number, rsp_bus.header_number);
         check_field("header_length", want.header_length, rsp_bus.header_length);
         check_field("merged_offset", want.merged_offset, rsp_bus.merged_offset);
         check_field("data_byte", 32'(want.data_byte), 32'(rsp_bus.data_byte));
         check_field("header_done", 32'(want.header_done), 32'(rsp_bus.header_done));
         check_field("error_code", 32'(want.error_code), 32'(rsp_bus.error_code));
         checked_count++;
         if (want.kind == KIND_OK) ok_count++;
         else if (want.kind == KIND_ERR) err_count++;
         else if (want.kind == KIND_BEGIN) begin_count++;
      end
   endtask

   // driver
   deframer_beat_type in_flight;
   int gap_left = 0;
   int req_mode = 0;
   int req_mode_left = 0;

   always @(posedge clock) begin
      if (reset) begin
         drv_valid <= 1'b0;
      end else begin
         if (drv_valid && req_bus.ready) begin
            deframe_beat(in_flight);
            n_accepted++;
         end
         if (!drv_valid || req_bus.ready) begin
            if (gap_left > 0) begin
               gap_left--;
               drv_valid <= 1'b0;
            end else if (pending_beats.size() > 0) begin
               in_flight = pending_beats.pop_front();
               drv_func <= in_flight.func;
               drv_index <= in_flight.segment_index;
               drv_byte <= in_flight.body_byte;
               drv_last <= in_flight.segment_last;
               drv_valid <= 1'b1;
               if (burst_now(req_mode)) gap_left = $urandom_range(1, 14);
            end else begin
               drv_valid <= 1'b0;
            end
         end
         if (req_mode_left == 0) begin
            req_mode = $urandom_range(0, 2);
            req_mode_left = $urandom_range(20, 300);
         end else begin
            req_mode_left--;
         end
      end
   end

   // monitor
   int stall_left = 0;
   int rsp_mode = 0;
   int rsp_mode_left = 0;

   always @(posedge clock) begin
      if (reset) begin
         take_rsp <= 1'b0;
      end else begin
         if (rsp_bus.valid && take_rsp) check_report();
         if (stall_left > 0) begin
            stall_left--;
            take_rsp <= 1'b0;
         end else if (burst_now(rsp_mode)) begin
            stall_left = $urandom_range(0, 13);
            take_rsp <= 1'b0;
         end else begin
            take_rsp <= 1'b1;
         end
         if (rsp_mode_left == 0) begin
            rsp_mode = $urandom_range(0, 2);
            rsp_mode_left = $urandom_range(20, 300);
         end else begin
            rsp_mode_left--;
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("%0t: timeout, %0d results still expected", $time, expected_reports.size());
         $display("tb_top failed");
         $finish;
      end
   end

   initial begin
      // stray byte before any segment, then an ignored function code
      add_beat(FUNC_BYTE, 8'h00, 8'hFF, 1'b1);
      add_beat(FUNC_NONE, 8'hFF, 8'hFF, 1'b1);
      // empty header, then a one-byte header whose data sits in the next segment
      add_beat(FUNC_START, 8'd0, 8'h00, 1'b0);
      put_len(32'd0, 1'b0);
      put_len(32'd1, 1'b1);
      add_beat(FUNC_START, 8'd255, 8'h00, 1'b0);
      add_beat(FUNC_BYTE, 8'h00, 8'h00, 1'b0);
      add_beat(FUNC_FINISH, 8'h00, 8'h00, 1'b0);
      // empty segment, then a start ignored while failed
      add_beat(FUNC_START, 8'd5, 8'h00, 1'b0);
      add_beat(FUNC_START, 8'd6, 8'h00, 1'b0);
      add_beat(FUNC_START, 8'd9, 8'h00, 1'b0);
      add_beat(FUNC_FINISH, 8'h00, 8'h00, 1'b0);
      // length field cut by the segment end
      add_beat(FUNC_START, 8'd3, 8'h00, 1'b0);
      add_beat(FUNC_BYTE, 8'h00, 8'h00, 1'b1);
      add_beat(FUNC_FINISH, 8'h00, 8'h00, 1'b0);
      // repeated index
      add_beat(FUNC_START, 8'd1, 8'h00, 1'b0);
      put_len(32'd0, 1'b0);
      add_beat(FUNC_START, 8'd1, 8'h00, 1'b0);
      add_beat(FUNC_FINISH, 8'h00, 8'h00, 1'b0);
      // header data still missing at finish
      add_beat(FUNC_START, 8'd2, 8'h00, 1'b0);
      put_len(32'd2, 1'b0);
      add_beat(FUNC_BYTE, 8'h00, 8'hAB, 1'b0);
      add_beat(FUNC_FINISH, 8'h00, 8'h00, 1'b0);

      noise_on = 1'b1;
      counted_beats = 0;
      while (counted_beats < RANDOM_BEATS) queue_frame($urandom_range(0, 3) == 0);
      beats_total = pending_beats.size();

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      while (n_accepted != beats_total || expected_reports.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);

      $display("%0d segment runs, %0d beats accepted, %0d results checked",
               frame_count + 5, n_accepted, checked_count);
      $display("%0d headers begun, %0d clean finishes, %0d error reports",
               begin_count, ok_count, err_count);
      if (fail_count == 0) begin
         $display("tb_top passed");
      end else begin
         $display("tb_top failed");
      end
      $finish;
   end

endmodule
